[src/alu8f_pkg.sv]
// Package for the 8-bit ALU with flags: operation codes, flag positions,
// decimal adjust constants and the request/response payload structs.
// No dependencies.
package alu8f_pkg;

	// Operation codes carried in the action field
	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADC  = 5'd1,
		OP_SUB  = 5'd2,
		OP_SBC  = 5'd3,
		OP_AND  = 5'd4,
		OP_XOR  = 5'd5,
		OP_OR   = 5'd6,
		OP_CP   = 5'd7,
		OP_INC  = 5'd8,
		OP_DEC  = 5'd9,
		OP_DAA  = 5'd10,
		OP_CPL  = 5'd11,
		OP_CCF  = 5'd12,
		OP_SCF  = 5'd13,
		OP_RLC  = 5'd14,
		OP_RRC  = 5'd15,
		OP_RL   = 5'd16,
		OP_RR   = 5'd17,
		OP_SLA  = 5'd18,
		OP_SRA  = 5'd19,
		OP_SWAP = 5'd20,
		OP_SRL  = 5'd21,
		OP_BIT  = 5'd22,
		OP_RES  = 5'd23,
		OP_SET  = 5'd24,
		OP_RLCA = 5'd25,
		OP_RRCA = 5'd26,
		OP_RLA  = 5'd27,
		OP_RRA  = 5'd28
	} alu_op_t;

	// Flag bit positions in flags_in / flags_out
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// Decimal adjust corrections and limit
	localparam logic [7:0] DAA_ADJ_LO = 8'h06;
	localparam logic [7:0] DAA_ADJ_HI = 8'h60;
	localparam logic [7:0] DAA_LIMIT  = 8'h99;
	localparam logic [3:0] DAA_NIB_LIMIT = 4'h9;

	typedef struct packed {
		logic [4:0] action;
		logic [7:0] acc;
		logic [7:0] operand;
		logic [2:0] bit_index;
		logic [3:0] flags_in;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags_out;
		logic       writes_result;
	} alu_rsp_t;

endpackage

[src/alu8f_if.sv]
// Valid/ready channel interfaces for the ALU request and response.
// No dependencies.
interface alu8f_req_if;
	logic       valid;
	logic       ready;
	logic [4:0] action;
	logic [7:0] acc;
	logic [7:0] operand;
	logic [2:0] bit_index;
	logic [3:0] flags_in;

	modport source(output valid, action, acc, operand, bit_index, flags_in, input ready);
	modport sink(input valid, action, acc, operand, bit_index, flags_in, output ready);
endinterface

interface alu8f_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic [3:0] flags_out;
	logic       writes_result;

	modport source(output valid, result, flags_out, writes_result, input ready);
	modport sink(input valid, result, flags_out, writes_result, output ready);
endinterface

[src/alu8f_core.sv]
// Combinational ALU datapath: result byte, new flags and write enable for one request.
// Depends on alu8f_pkg.
module alu8f_core import alu8f_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [7:0] a;
	logic [7:0] v;
	logic [3:0] f;
	logic       c;

	logic       cin_add;
	logic       cin_sub;
	logic [8:0] sum9;
	logic [4:0] hsum5;
	logic [8:0] diff9;
	logic [4:0] hdiff5;
	logic [7:0] inc8;
	logic [7:0] dec8;

	logic       daa_hi;
	logic       daa_lo;
	logic [7:0] daa8;
	logic       daa_c;

	logic       acc_rot;
	logic [7:0] sh_src;
	logic [7:0] sh8;
	logic       sh_c;
	logic [7:0] bit_mask;

	assign a = req.acc;
	assign v = req.operand;
	assign f = req.flags_in;
	assign c = f[FLAG_C];

	// Add and subtract with optional carry in; bit 8 / bit 4 give carry and half carry
	assign cin_add = (req.action == OP_ADC) && c;
	assign cin_sub = (req.action == OP_SBC) && c;
	assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, cin_add};
	assign hsum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin_add};
	assign diff9  = {1'b0, a} - {1'b0, v} - {8'd0, cin_sub};
	assign hdiff5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin_sub};
	assign inc8   = v + 8'd1;
	assign dec8   = v - 8'd1;

	// Decimal adjust: after subtract only undo the flagged corrections
	always_comb begin
		daa_hi = c || (a > DAA_LIMIT);
		daa_lo = f[FLAG_H] || (a[3:0] > DAA_NIB_LIMIT);
		if (f[FLAG_N]) begin
			daa8 = a - (f[FLAG_H] ? DAA_ADJ_LO : 8'd0) - (c ? DAA_ADJ_HI : 8'd0);
			daa_c = c;
		end else begin
			daa8 = a + (daa_hi ? DAA_ADJ_HI : 8'd0) + (daa_lo ? DAA_ADJ_LO : 8'd0);
			daa_c = daa_hi;
		end
	end

	// Rotates and shifts: accumulator forms take acc, the others the operand
	assign acc_rot = (req.action == OP_RLCA) || (req.action == OP_RRCA) ||
			(req.action == OP_RLA) || (req.action == OP_RRA);
	assign sh_src = acc_rot ? a : v;

	always_comb begin
		sh8  = sh_src;
		sh_c = 1'b0;
		unique case (req.action)
			OP_RLC, OP_RLCA: begin
				sh8  = {sh_src[6:0], sh_src[7]};
				sh_c = sh_src[7];
			end
			OP_RRC, OP_RRCA: begin
				sh8  = {sh_src[0], sh_src[7:1]};
				sh_c = sh_src[0];
			end
			OP_RL, OP_RLA: begin
				sh8  = {sh_src[6:0], c};
				sh_c = sh_src[7];
			end
			OP_RR, OP_RRA: begin
				sh8  = {c, sh_src[7:1]};
				sh_c = sh_src[0];
			end
			OP_SLA: begin
				sh8  = {sh_src[6:0], 1'b0};
				sh_c = sh_src[7];
			end
			OP_SRA: begin
				sh8  = {sh_src[7], sh_src[7:1]};
				sh_c = sh_src[0];
			end
			OP_SWAP: begin
				sh8  = {sh_src[3:0], sh_src[7:4]};
				sh_c = 1'b0;
			end
			OP_SRL: begin
				sh8  = {1'b0, sh_src[7:1]};
				sh_c = sh_src[0];
			end
			default: begin
				sh8  = sh_src;
				sh_c = 1'b0;
			end
		endcase
	end

	assign bit_mask = 8'd1 << req.bit_index;

	// Select result, flags and write enable per operation
	always_comb begin
		rsp.result        = 8'd0;
		rsp.flags_out     = f;
		rsp.writes_result = 1'b1;
		unique case (req.action)
			OP_ADD, OP_ADC: begin
				rsp.result    = sum9[7:0];
				rsp.flags_out = {sum9[7:0] == 8'd0, 1'b0, hsum5[4], sum9[8]};
			end
			OP_SUB, OP_SBC: begin
				rsp.result    = diff9[7:0];
				rsp.flags_out = {diff9[7:0] == 8'd0, 1'b1, hdiff5[4], diff9[8]};
			end
			OP_CP: begin
				rsp.flags_out     = {diff9[7:0] == 8'd0, 1'b1, hdiff5[4], diff9[8]};
				rsp.writes_result = 1'b0;
			end
			OP_AND: begin
				rsp.result    = a & v;
				rsp.flags_out = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR: begin
				rsp.result    = a ^ v;
				rsp.flags_out = {(a ^ v) == 8'd0, 1'b0, 1'b0, 1'b0};
			end
			OP_OR: begin
				rsp.result    = a | v;
				rsp.flags_out = {(a | v) == 8'd0, 1'b0, 1'b0, 1'b0};
			end
			OP_INC: begin
				rsp.result    = inc8;
				rsp.flags_out = {inc8 == 8'd0, 1'b0, v[3:0] == 4'hf, c};
			end
			OP_DEC: begin
				rsp.result    = dec8;
				rsp.flags_out = {dec8 == 8'd0, 1'b1, v[3:0] == 4'h0, c};
			end
			OP_DAA: begin
				rsp.result    = daa8;
				rsp.flags_out = {daa8 == 8'd0, f[FLAG_N], 1'b0, daa_c};
			end
			OP_CPL: begin
				rsp.result    = ~a;
				rsp.flags_out = {f[FLAG_Z], 1'b1, 1'b1, c};
			end
			OP_CCF: begin
				rsp.flags_out     = {f[FLAG_Z], 1'b0, 1'b0, ~c};
				rsp.writes_result = 1'b0;
			end
			OP_SCF: begin
				rsp.flags_out     = {f[FLAG_Z], 1'b0, 1'b0, 1'b1};
				rsp.writes_result = 1'b0;
			end
			OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
				rsp.result    = sh8;
				rsp.flags_out = {sh8 == 8'd0, 1'b0, 1'b0, sh_c};
			end
			OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
				// accumulator rotates always clear zero
				rsp.result    = sh8;
				rsp.flags_out = {1'b0, 1'b0, 1'b0, sh_c};
			end
			OP_BIT: begin
				rsp.flags_out     = {~|(v & bit_mask), 1'b0, 1'b1, c};
				rsp.writes_result = 1'b0;
			end
			OP_RES: begin
				rsp.result = v & ~bit_mask;
			end
			OP_SET: begin
				rsp.result = v | bit_mask;
			end
			default: begin
				// unused codes: no result, flags pass through
				rsp.result        = 8'd0;
				rsp.flags_out     = f;
				rsp.writes_result = 1'b0;
			end
		endcase
	end

endmodule

[src/eight_bit_cpu_alu_with_flags.sv]
// Top level of the 8-bit ALU with flags: request register, ALU datapath, response register.
// Depends on alu8f_pkg, alu8f_req_if / alu8f_rsp_if and alu8f_core.
//
// Usage:
//   req  - request channel (valid/ready): action, acc, operand, bit_index, flags_in.
//   rsp  - response channel (valid/ready): result, flags_out, writes_result.
//   Every request yields exactly one response, in request order.
// Path: a taken request is held in the request register, goes through the ALU
//   and is held in the response register, which drives rsp.
// Throughput: one request per cycle while rsp.ready stays high, set by the single
//   ALU pass between the request register and the response register.
// Stalls: while rsp.ready is low the response register holds its payload; the
//   request register still takes one more request if it is empty, and req.ready
//   drops once both registers are full.
// Reset: arst_n clears both valid bits at once; no response is pending after reset.
module eight_bit_cpu_alu_with_flags import alu8f_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	alu8f_req_if.sink   req,
	alu8f_rsp_if.source rsp
);

	logic     valid_s1;
	logic     valid_s2;
	alu_req_t req_s1;
	alu_rsp_t rsp_s2;
	alu_rsp_t rsp_d;
	logic     adv_s1;
	logic     adv_s2;

	// Advance each stage when its downstream has room
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (req.valid && adv_s1) begin
			req_s1 <= '{action: req.action, acc: req.acc, operand: req.operand,
					bit_index: req.bit_index, flags_in: req.flags_in};
		end
	end

	alu8f_core u_core (
		.req (req_s1),
		.rsp (rsp_d)
	);

	// Hold the response until it is taken
	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.result        = rsp_s2.result;
	assign rsp.flags_out     = rsp_s2.flags_out;
	assign rsp.writes_result = rsp_s2.writes_result;

endmodule

[src/alu8f_checker.sv]
// Port-level checks for the 8-bit ALU with flags, bound to the top level.
// Depends on the top level eight_bit_cpu_alu_with_flags.
module alu8f_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_result,
	input logic [3:0] rsp_flags_out,
	input logic       rsp_writes_result
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result) && $stable(rsp_flags_out) &&
			$stable(rsp_writes_result))
		else $error("stalled response changed");

	// A taken request followed by a free response side yields a valid response
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
		else $error("response missing after request");

	// Responses without write-back carry a zero result byte
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_writes_result |-> rsp_result == 8'd0)
		else $error("nonzero result without write-back");

endmodule

bind eight_bit_cpu_alu_with_flags alu8f_checker u_alu8f_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_result        (rsp.result),
	.rsp_flags_out     (rsp.flags_out),
	.rsp_writes_result (rsp.writes_result)
);
